[src/mwg_pkg.sv]
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared types, codes and the quarter-wave sine table for the waveform
// generator.
// ----------------------------------------------------------------------------
package mwg_pkg;

    // output sample format
    localparam int AMPLITUDE = 127;
    localparam int MAG_W     = 7;
    localparam int SAMPLE_W  = 8;

    // sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER         = 1 << QUARTER_BITS;

    // apb port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int STEP_W = 32;

    // fixed point constants for the sine series
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // register reset values
    localparam logic [2:0]        WAVE_SEL_RESET   = 3'd0;
    localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd42852281;
    localparam int                DUTY_RESET       = 1966;

    typedef enum logic [2:0] {
        WAVE_PULSE    = 3'd0,
        WAVE_SAW      = 3'd1,
        WAVE_SINE     = 3'd2,
        WAVE_SQUARE   = 3'd3,
        WAVE_TRIANGLE = 3'd4
    } wave_t;

    typedef enum logic [1:0] {
        REG_WAVE_SEL   = 2'd0,
        REG_PHASE_STEP = 2'd1,
        REG_DUTY       = 2'd2
    } reg_idx_t;

    typedef logic [MAG_W-1:0] mag_t;
    typedef mag_t sine_tab_t [QUARTER];

    // quarter-wave magnitudes, taylor series up to x^11 in q30, built at elaboration
    function automatic sine_tab_t sine_table_init();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int i = 0; i < QUARTER; i++)
        begin
            x  = (64'(i) * HALF_PI_Q30) >> QUARTER_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - x2 / 64'd110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            if (s > ONE_Q30)
            begin
                s = ONE_Q30;
            end
            tab[i] = MAG_W'((64'(AMPLITUDE) * s) >> 30);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = sine_table_init();

endpackage

[src/mwg_cfg.sv]
// ----------------------------------------------------------------------------
// mwg_cfg
// APB register file: waveform select, phase step and pulse duty.
// ----------------------------------------------------------------------------
module mwg_cfg import mwg_pkg::*;
#(
    parameter int DUTY_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    output logic [2:0]           wave_sel,
    output logic [STEP_W-1:0]    phase_step,
    output logic [DUTY_BITS-1:0] duty_fraction
);

    logic [2:0]           wave_sel_reg;
    logic [STEP_W-1:0]    phase_step_reg;
    logic [DUTY_BITS-1:0] duty_reg;
    logic                 wr_en;
    reg_idx_t             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_sel_reg   <= WAVE_SEL_RESET;
            phase_step_reg <= PHASE_STEP_RESET;
            duty_reg       <= DUTY_BITS'(DUTY_RESET);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WAVE_SEL:   wave_sel_reg   <= pwdata[2:0];
                REG_PHASE_STEP: phase_step_reg <= pwdata[STEP_W-1:0];
                REG_DUTY:       duty_reg       <= pwdata[DUTY_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_WAVE_SEL:   prdata = DATA_W'(wave_sel_reg);
            REG_PHASE_STEP: prdata = DATA_W'(phase_step_reg);
            REG_DUTY:       prdata = DATA_W'(duty_reg);
            default:        prdata = '0;
        endcase
    end

    assign wave_sel      = wave_sel_reg;
    assign phase_step    = phase_step_reg;
    assign duty_fraction = duty_reg;

endmodule

[src/mwg_phase.sv]
// ----------------------------------------------------------------------------
// mwg_phase
// Phase accumulator with restart, and the captured phase of each transfer.
// ----------------------------------------------------------------------------
module mwg_phase import mwg_pkg::*;
#(
    parameter int PHASE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  restart,
    input  logic [STEP_W-1:0]     phase_step,
    output logic [PHASE_BITS-1:0] sample_phase
);

    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    logic [PHASE_BITS-1:0] tap_reg;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [PHASE_BITS-1:0] step_ext;

    // restart clears the phase before the sample is taken
    assign step_ext  = PHASE_BITS'(phase_step);
    assign cur_phase = restart ? '0 : acc_reg;
    assign acc_next  = cur_phase + step_ext;

    // accumulator, wraps at a full turn
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg <= acc_next;
        end
    end

    // phase handed to the shaper
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tap_reg <= cur_phase;
        end
    end

    assign sample_phase = tap_reg;

`ifndef SYNTHESIS
    a_restart_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && restart |=> acc_reg == PHASE_BITS'($past(phase_step)))
        else $error("phase after restart is not one step");
`endif

endmodule

[src/mwg_shape.sv]
// ----------------------------------------------------------------------------
// mwg_shape
// Maps one phase to a signed sample for the selected waveform.
// ----------------------------------------------------------------------------
module mwg_shape import mwg_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int DUTY_BITS  = 16
)
(
    input  logic [PHASE_BITS-1:0]      phase,
    input  logic [2:0]                 wave_sel,
    input  logic [DUTY_BITS-1:0]       duty_fraction,
    output logic signed [SAMPLE_W-1:0] sample
);

    localparam int CMP_W = (PHASE_BITS > DUTY_BITS) ? PHASE_BITS : DUTY_BITS;
    localparam int P_W   = PHASE_BITS + MAG_W;
    localparam int unsigned DUTY_DEFAULT = (3 * (2 ** DUTY_BITS) + 50) / 100;
    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS-2:0] QTR  = {1'b1, {(PHASE_BITS-2){1'b0}}};

    logic                    upper;
    logic [PHASE_BITS-2:0]   low;
    logic [DUTY_BITS-1:0]    width;
    logic [CMP_W-1:0]        p_al;
    logic [CMP_W-1:0]        off_al;
    logic [CMP_W-1:0]        w_al;
    logic [PHASE_BITS-1:0]   saw_d;
    logic [PHASE_BITS-2:0]   tri_d;
    logic                    tri_pos;
    mag_t                    saw_mag;
    mag_t                    tri_mag;
    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] r;
    logic [QUARTER_BITS-1:0] sin_idx;
    mag_t                    sin_mag;
    logic                    neg;
    mag_t                    mag;

    assign upper = phase[PHASE_BITS-1];
    assign low   = phase[PHASE_BITS-2:0];

    // pulse width aligned against the phase
    assign width  = (duty_fraction == '0) ? DUTY_BITS'(DUTY_DEFAULT) : duty_fraction;
    assign p_al   = CMP_W'(phase) << (CMP_W - PHASE_BITS);
    assign off_al = CMP_W'(low) << (CMP_W - PHASE_BITS);
    assign w_al   = CMP_W'(width) << (CMP_W - DUTY_BITS);

    // sawtooth: distance from half turn scaled by amplitude
    assign saw_d   = upper ? PHASE_BITS'(low) : (HALF - phase);
    assign saw_mag = MAG_W'((P_W'(AMPLITUDE) * P_W'(saw_d)) >> (PHASE_BITS - 1));

    // triangle: distance from quarter point within each half
    assign tri_d   = (low >= QTR) ? (low - QTR) : (QTR - low);
    assign tri_pos = (low >= QTR) ^ upper;
    assign tri_mag = MAG_W'((P_W'(AMPLITUDE) * P_W'(tri_d)) >> (PHASE_BITS - 2));

    // sine: fold the top bits into a quarter-wave lookup
    assign k       = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad    = k[SINE_TABLE_BITS-1 -: 2];
    assign r       = k[QUARTER_BITS-1:0];
    assign sin_idx = quad[0] ? QUARTER_BITS'(~r + 1'b1) : r;
    assign sin_mag = (quad[0] && (r == '0)) ? MAG_W'(AMPLITUDE) : SINE_TABLE[sin_idx];

    // waveform select
    always_comb
    begin
        neg = 1'b0;
        mag = '0;
        case (wave_t'(wave_sel))
            WAVE_PULSE:
            begin
                if (p_al < w_al)
                begin
                    neg = 1'b1;
                    mag = MAG_W'(AMPLITUDE);
                end
                else if (upper && (off_al < w_al))
                begin
                    mag = MAG_W'(AMPLITUDE);
                end
            end
            WAVE_SAW:
            begin
                neg = !upper;
                mag = saw_mag;
            end
            WAVE_SINE:
            begin
                neg = quad[1];
                mag = sin_mag;
            end
            WAVE_SQUARE:
            begin
                neg = upper;
                mag = MAG_W'(AMPLITUDE);
            end
            WAVE_TRIANGLE:
            begin
                neg = !tri_pos;
                mag = tri_mag;
            end
            default:
            begin
                neg = 1'b0;
                mag = '0;
            end
        endcase
    end

    // apply sign
    assign sample = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

[src/multi_waveform_generator_unit.sv]
// ----------------------------------------------------------------------------
// multi_waveform_generator_unit: dds phase accumulator with five waveforms
// pipeline: accepted phase held in the tap register, shaped sample in the sample register
// throughput: one sample per cycle unless stalled; the accumulator add is the only feedback
// reset: phase clears to zero, registers take their defaults, no sample pending
// ----------------------------------------------------------------------------
module multi_waveform_generator_unit import mwg_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int DUTY_BITS  = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample
);

    logic [2:0]                 wave_sel;
    logic [STEP_W-1:0]          phase_step;
    logic [DUTY_BITS-1:0]       duty_fraction;
    logic [PHASE_BITS-1:0]      sample_phase;
    logic signed [SAMPLE_W-1:0] shaped;
    logic                       in_fire;
    logic                       out_free;
    logic                       s1_move;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;

    // configuration registers
    mwg_cfg #(
        .DUTY_BITS (DUTY_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .wave_sel      (wave_sel),
        .phase_step    (phase_step),
        .duty_fraction (duty_fraction)
    );

    // phase accumulator and tap register
    mwg_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_fire),
        .restart      (restart),
        .phase_step   (phase_step),
        .sample_phase (sample_phase)
    );

    // waveform shaping
    mwg_shape #(
        .PHASE_BITS (PHASE_BITS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_shape (
        .phase         (sample_phase),
        .wave_sel      (wave_sel),
        .duty_fraction (duty_fraction),
        .sample        (shaped)
    );

    // pipeline flow control
    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sample register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            sample_reg <= shaped;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("input transfer did not reach the phase tap");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |=> s1_valid_reg && out_valid_reg)
        else $error("pending sample dropped during stall");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != -8'sd128)
        else $error("sample outside amplitude range");
`endif

endmodule
